// ----- rtl/exe_pkg.sv -----
// ============================================================================
// exe_pkg
// Shared types, constants and helpers for the export name escaper.
// ============================================================================
`default_nettype none

package exe_pkg;

    localparam int BYTE_W   = 8;
    localparam int ESC_LEN  = 4;
    localparam int BUF_LEN  = 2 * ESC_LEN;
    localparam int CNT_W    = $clog2(BUF_LEN + 1);

    localparam logic [BYTE_W-1:0] UNDERSCORE = 8'h5F;

    typedef struct packed {
        logic                             keep;
        logic [ESC_LEN-1:0][BYTE_W-1:0]   bytes;
    } t_enc;

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] ext;
        ext = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_digit = 8'h30 + ext;
        end else begin
            hex_digit = 8'h57 + ext;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/export_name_escaper.sv -----
// ============================================================================
// export_name_escaper
// Escapes a streamed name, holding each byte back one word to see the next.
// ============================================================================
// First result word: in the cycle after the input word is accepted.
// Throughput: each input yields 0 to 8 result words, one per cycle while the
// receiver is ready; a new input is taken only when no pending word is left
// or the last one leaves, so every cycle while each yields at most one.
// Reset: synchronous, active low; drops the held byte and any pending words.
`default_nettype none

module export_name_escaper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic        i_s_axis_tlast,   // in_last
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [7:0] out_byte
    output logic             o_m_axis_tlast,   // run_end
    output logic             o_m_axis_tuser    // [0] name_end
);

    localparam int BL = exe_pkg::BUF_LEN;
    localparam int CW = exe_pkg::CNT_W;

    logic [BL-1:0][7:0] r_buf,  n_buf;
    logic [CW-1:0]      r_cnt,  n_cnt;
    logic               r_name, n_name;
    logic               r_held_valid, n_held_valid;
    logic [7:0]         r_held_byte,  n_held_byte;
    logic               r_held_first, n_held_first;

    exe_pkg::t_enc      held_enc;
    exe_pkg::t_enc      cur_enc;
    logic               in_acc;
    logic               pop;
    logic [CW-1:0]      len_h;
    logic [CW-1:0]      len_c;
    logic [BL-1:0][7:0] build;

    exe_encode u_enc_held (
        .i_byte    (r_held_byte),
        .i_first   (r_held_first),
        .i_next_us (i_s_axis_tdata == exe_pkg::UNDERSCORE),
        .o_enc     (held_enc)
    );

    exe_encode u_enc_cur (
        .i_byte    (i_s_axis_tdata),
        .i_first   (!r_held_valid),
        .i_next_us (1'b0),
        .o_enc     (cur_enc)
    );

    always_comb begin
        o_m_axis_tvalid = (r_cnt != '0);
        o_m_axis_tdata  = r_buf[0];
        o_m_axis_tlast  = (r_cnt == CW'(1));
        o_m_axis_tuser  = r_name && (r_cnt == CW'(1));
        pop             = o_m_axis_tvalid && i_m_axis_tready;
        o_s_axis_tready = (r_cnt == '0) || ((r_cnt == CW'(1)) && i_m_axis_tready);
        in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    end

    always_comb begin
        if (!r_held_valid) begin
            len_h = '0;
        end else if (held_enc.keep) begin
            len_h = CW'(1);
        end else begin
            len_h = CW'(exe_pkg::ESC_LEN);
        end

        if (!i_s_axis_tlast) begin
            len_c = '0;
        end else if (cur_enc.keep) begin
            len_c = CW'(1);
        end else begin
            len_c = CW'(exe_pkg::ESC_LEN);
        end

        build = '0;
        case (len_h)
            CW'(0): begin
                build[3:0] = cur_enc.bytes;
            end
            CW'(1): begin
                build[0]   = held_enc.bytes[0];
                build[4:1] = cur_enc.bytes;
            end
            default: begin
                build[3:0] = held_enc.bytes;
                build[7:4] = cur_enc.bytes;
            end
        endcase
    end

    always_comb begin
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_name       = r_name;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        n_held_first = r_held_first;

        if (pop) begin
            n_cnt = r_cnt - CW'(1);
            n_buf = {8'h00, r_buf[BL-1:1]};
        end

        if (in_acc) begin
            n_buf  = build;
            n_cnt  = len_h + len_c;
            n_name = i_s_axis_tlast;
            if (i_s_axis_tlast) begin
                n_held_valid = 1'b0;
                n_held_byte  = 8'h00;
                n_held_first = 1'b0;
            end else begin
                n_held_first = !r_held_valid;
                n_held_byte  = i_s_axis_tdata;
                n_held_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf        <= n_buf;
        r_held_byte  <= n_held_byte;
        r_held_first <= n_held_first;
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_name       <= 1'b0;
            r_held_valid <= 1'b0;
        end else begin
            r_cnt        <= n_cnt;
            r_name       <= n_name;
            r_held_valid <= n_held_valid;
        end
    end

    a_name_end_on_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("name_end without run_end");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(BL))
        else $error("pending word count out of range");

    a_last_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tlast) |=> (!r_held_valid && o_m_axis_tvalid))
        else $error("final byte left a held byte or no result");

    a_first_byte_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_s_axis_tlast && !r_held_valid) |=> (!o_m_axis_tvalid && r_held_first))
        else $error("first byte of a name produced output");

endmodule

`default_nettype wire

// ----- rtl/exe_encode.sv -----
// ============================================================================
// exe_encode
// Escapes one byte: pass it through, or expand it to "__" and two hex digits.
// ============================================================================
`default_nettype none

module exe_encode (
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_first,
    input  wire logic         i_next_us,
    output exe_pkg::t_enc     o_enc
);

    logic is_letter;
    logic is_digit;
    logic keep;

    always_comb begin
        is_letter = ((i_byte >= 8'h41) && (i_byte <= 8'h5A)) ||
                    ((i_byte >= 8'h61) && (i_byte <= 8'h7A));
        is_digit  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        keep      = (i_first ? is_letter : (is_letter || is_digit)) ||
                    ((i_byte == exe_pkg::UNDERSCORE) && !i_next_us);

        o_enc.keep = keep;
        if (keep) begin
            o_enc.bytes    = '0;
            o_enc.bytes[0] = i_byte;
        end else begin
            o_enc.bytes[0] = exe_pkg::UNDERSCORE;
            o_enc.bytes[1] = exe_pkg::UNDERSCORE;
            o_enc.bytes[2] = exe_pkg::hex_digit(i_byte[7:4]);
            o_enc.bytes[3] = exe_pkg::hex_digit(i_byte[3:0]);
        end
    end

endmodule

`default_nettype wire

// ----- dv/export_name_escaper_tb.sv -----
// ============================================================================
// export_name_escaper_tb
// Self-checking bench for the export name escaper. Sends names as byte words
// with tlast on the final byte, and predicts every escaped output word. The
// predictor holds each byte back to see its successor. Output words are
// checked in order on data, tlast (run end) and tuser (name end). Both sides
// idle at random, the receiver holds off once for a long stretch, and the
// run ends with a stretch that has no idling.
// ============================================================================
`default_nettype none

module export_name_escaper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       name_end;
    } t_esc_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;     // [7:0] in_byte
    logic       i_s_axis_tlast;     // in_last
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;     // [7:0] out_byte
    logic       o_m_axis_tlast;     // run_end
    logic       o_m_axis_tuser;     // [0] name_end

    t_esc_word  escaped_q[$];
    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_first;

    int         error_count  = 0;
    int         stuck_cycles = 0;
    int         hold_request = 0;
    int         rx_stall     = 0;
    bit         rx_idle_on   = 1'b1;
    bit         tx_idle_on   = 1'b1;

    export_name_escaper u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] v;
        v = {4'h0, nib};
        return (nib > 4'd9) ? v + 8'h61 - 8'd10 : v + 8'h30;
    endfunction

    function automatic bit passes_through(input logic [7:0] c, input bit first,
                                          input bit next_us);
        bit letter;
        bit digit;
        letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        digit  = (c >= 8'h30 && c <= 8'h39);
        return (first ? letter : (letter || digit)) ||
               (c == exe_pkg::UNDERSCORE && !next_us);
    endfunction

    function automatic void push_escaped(input logic [7:0] c, input bit first,
                                         input bit next_us);
        if (passes_through(c, first, next_us)) begin
            escaped_q.push_back('{c, 1'b0, 1'b0});
        end else begin
            escaped_q.push_back('{exe_pkg::UNDERSCORE, 1'b0, 1'b0});
            escaped_q.push_back('{exe_pkg::UNDERSCORE, 1'b0, 1'b0});
            escaped_q.push_back('{hex_char(c[7:4]), 1'b0, 1'b0});
            escaped_q.push_back('{hex_char(c[3:0]), 1'b0, 1'b0});
        end
    endfunction

    function automatic void predict_escape_step(input logic [7:0] b, input bit last);
        int        start;
        t_esc_word w;
        start = escaped_q.size();
        if (held_valid) begin
            push_escaped(held_byte, held_first, b == exe_pkg::UNDERSCORE);
        end
        if (last) begin
            push_escaped(b, !held_valid, 1'b0);
            held_valid = 1'b0;
            held_byte  = 8'h00;
            held_first = 1'b0;
        end else begin
            held_first = !held_valid;
            held_byte  = b;
            held_valid = 1'b1;
        end
        if (escaped_q.size() > start) begin
            w = escaped_q.pop_back();
            w.run_end  = 1'b1;
            w.name_end = last;
            escaped_q.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // predict on accepted input, check accepted output
    always @(posedge i_clk) begin
        t_esc_word want;
        if (!i_rst_n) begin
            held_valid = 1'b0;
            held_byte  = 8'h00;
            held_first = 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_escape_step(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (escaped_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", o_m_axis_tdata));
                end else begin
                    want = escaped_q.pop_front();
                    if (o_m_axis_tdata !== want.data) begin
                        report_mismatch($sformatf("data %h, want %h",
                                                  o_m_axis_tdata, want.data));
                    end
                    if (o_m_axis_tlast !== want.run_end) begin
                        report_mismatch($sformatf("run end %b, want %b",
                                                  o_m_axis_tlast, want.run_end));
                    end
                    if (o_m_axis_tuser !== want.name_end) begin
                        report_mismatch($sformatf("name end %b, want %b",
                                                  o_m_axis_tuser, want.name_end));
                    end
                end
            end
        end
    end

    // receiver: long hold-off, random stall bursts, else ready
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_request = hold_request - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall = rx_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rx_stall = $urandom_range(1, 7) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // leaves tvalid high on return; the caller drops it when the burst ends
    task automatic send_word(input logic [7:0] b, input bit last);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (escaped_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_name_byte();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(8'h41, 8'h5A));
            1, 2:    return 8'($urandom_range(8'h61, 8'h7A));
            3:       return 8'($urandom_range(8'h30, 8'h39));
            4, 5:    return exe_pkg::UNDERSCORE;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_random_names(input int n_words);
        int sent;
        int len;
        sent = 0;
        while (sent < n_words) begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                send_word(pick_name_byte(), i == len - 1);
            end
            sent += len;
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic test_directed_names();
        logic [8:0] words [22] = '{
            9'h141, 9'h139, 9'h15F,
            9'h05F, 9'h15F,
            9'h05F, 9'h161,
            9'h07A, 9'h030, 9'h139,
            9'h05A, 9'h0FF, 9'h180,
            9'h001, 9'h07F, 9'h15F,
            9'h040, 9'h05B, 9'h060, 9'h07B, 9'h02F, 9'h13A
        };
        foreach (words[i]) begin
            send_word(words[i][7:0], words[i][8]);
        end
        wait_drained();
    endtask

    task automatic test_random_names();
        send_random_names(95);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        hold_request = 80;
        tx_idle_on   = 1'b0;
        for (int i = 0; i < 24; i++) begin
            send_word(8'($urandom_range(1, 255)), i % 6 == 5);
        end
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_streaming_no_idle();
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        send_random_names(30);
        wait_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_names();
        test_random_names();
        test_output_backpressure();
        test_streaming_no_idle();

        repeat (10) @(posedge i_clk);
        if (escaped_q.size() != 0) begin
            report_mismatch($sformatf("%0d words never arrived", escaped_q.size()));
        end
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
